// File: rtl/core/mdws_pkg.sv
package mdws_pkg;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_INDEX_W = 2;

	typedef enum logic [1:0] {
		OP_APP_TICK = 2'd0,
		OP_BUS_TICK = 2'd1,
		OP_TEXT_CHANGED = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_LIGHT_MODE = 2'd0,
		CFG_AUTO_OFF_MS = 2'd1,
		CFG_BUS_TIMEOUT_MS = 2'd2,
		CFG_METER_BUS_ADDRESS = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		BL_MODE_OFF = 2'd0,
		BL_MODE_ON = 2'd1,
		BL_MODE_AUTO = 2'd2
	} bl_mode_t;

	typedef enum logic [1:0] {
		WK_NONE = 2'd0,
		WK_SINGLE = 2'd1,
		WK_TEXT = 2'd2,
		WK_LABEL = 2'd3
	} write_kind_t;

	typedef enum logic [2:0] {
		SEQ_IDLE = 3'd0,
		SEQ_BACKLIGHT = 3'd1,
		SEQ_TEXT = 3'd2,
		SEQ_LABEL = 3'd3,
		SEQ_LCD_MODE = 3'd4
	} seq_t;

	localparam logic [15:0] REG_BACKLIGHT = 16'd7062;
	localparam logic [15:0] REG_LCD_MODE = 16'd7063;
	localparam logic [15:0] REG_TEXT = 16'd7064;
	localparam logic [15:0] REG_LABEL = 16'd7068;
	localparam logic [3:0] LCD_SHOW_ENERGY = 4'd1;
	localparam logic [3:0] LCD_SHOW_TEXT = 4'd8;

	localparam logic [1:0] RST_LIGHT_MODE = 2'd2;
	localparam logic [31:0] RST_AUTO_OFF_MS = 32'd300000;
	localparam logic [15:0] RST_BUS_TIMEOUT_MS = 16'd3000;
	localparam logic [7:0] RST_METER_BUS_ADDRESS = 8'd1;

	typedef struct packed {
		logic [1:0] op;
		logic [31:0] now_ms;
		logic ev_charging;
		logic button_down;
		logic [7:0] meter_kind;
		logic meter_has_display;
		logic response_ok;
		logic text_blank;
	} item_t;

	typedef struct packed {
		logic clear_request;
		logic [1:0] write_kind;
		logic [7:0] target_address;
		logic [15:0] register_address;
		logic [3:0] register_value;
		logic work_pending;
		logic backlight_wanted;
	} result_t;

	typedef struct packed {
		logic [1:0] light_mode;
		logic [31:0] auto_off_ms;
		logic [15:0] bus_timeout_ms;
		logic [7:0] meter_bus_address;
	} cfg_t;

	typedef struct packed {
		seq_t seq;
		logic [31:0] step_start_ms;
		logic [31:0] last_event_ms;
		logic bl_target;
		logic bl_sent;
		logic bl_sent_valid;
		logic text_due;
		logic text_is_blank;
		logic was_charging;
		logic was_pressed;
		logic [7:0] last_meter_kind;
	} state_t;

endpackage

// File: rtl/core/mdws_cfg_regs.sv
module mdws_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [mdws_pkg::CFG_INDEX_W-1:0] wr_index,
	input logic [mdws_pkg::CFG_DATA_W-1:0] wr_data,
	output mdws_pkg::cfg_t cfg
);

	mdws_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_mode <= mdws_pkg::RST_LIGHT_MODE;
			cfg_q.auto_off_ms <= mdws_pkg::RST_AUTO_OFF_MS;
			cfg_q.bus_timeout_ms <= mdws_pkg::RST_BUS_TIMEOUT_MS;
			cfg_q.meter_bus_address <= mdws_pkg::RST_METER_BUS_ADDRESS;
		end else if (wr_en) begin
			case (mdws_pkg::cfg_index_t'(wr_index))
				mdws_pkg::CFG_LIGHT_MODE: cfg_q.light_mode <= wr_data[1:0];
				mdws_pkg::CFG_AUTO_OFF_MS: cfg_q.auto_off_ms <= wr_data[31:0];
				mdws_pkg::CFG_BUS_TIMEOUT_MS: cfg_q.bus_timeout_ms <= wr_data[15:0];
				mdws_pkg::CFG_METER_BUS_ADDRESS: cfg_q.meter_bus_address <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/mdws_step.sv
module mdws_step (
	input mdws_pkg::item_t item,
	input mdws_pkg::state_t st,
	input mdws_pkg::cfg_t cfg,
	output mdws_pkg::state_t nxt,
	output mdws_pkg::result_t res
);

	logic [31:0] last_ev;
	logic [31:0] event_age;
	logic [31:0] step_age;
	logic bus_expired;
	mdws_pkg::write_kind_t kind;

	always_comb begin
		nxt = st;
		res = '0;
		kind = mdws_pkg::WK_NONE;
		last_ev = st.last_event_ms;
		event_age = '0;
		step_age = item.now_ms - st.step_start_ms;
		bus_expired = (st.seq != mdws_pkg::SEQ_IDLE) &&
			(step_age >= {16'd0, cfg.bus_timeout_ms});
		case (mdws_pkg::op_t'(item.op))
			mdws_pkg::OP_APP_TICK: begin
				if (item.meter_kind != st.last_meter_kind) begin
					nxt.last_meter_kind = item.meter_kind;
					if (item.meter_has_display) begin
						nxt.bl_sent_valid = 1'b0;
						if (!st.text_is_blank) begin
							nxt.text_due = 1'b1;
						end
					end
				end
				if (st.was_charging && !item.ev_charging) begin
					last_ev = item.now_ms;
				end
				if (item.button_down && !st.was_pressed) begin
					last_ev = item.now_ms;
				end
				nxt.was_charging = item.ev_charging;
				nxt.was_pressed = item.button_down;
				nxt.last_event_ms = last_ev;
				event_age = item.now_ms - last_ev;
				case (mdws_pkg::bl_mode_t'(cfg.light_mode))
					mdws_pkg::BL_MODE_OFF: nxt.bl_target = 1'b0;
					mdws_pkg::BL_MODE_ON: nxt.bl_target = 1'b1;
					default: nxt.bl_target = item.ev_charging ||
						((last_ev != 32'd0) && (event_age < cfg.auto_off_ms));
				endcase
			end
			mdws_pkg::OP_BUS_TICK: begin
				if (bus_expired) begin
					res.clear_request = 1'b1;
					nxt.text_due = 1'b0;
					nxt.bl_sent = st.bl_target;
					nxt.bl_sent_valid = 1'b1;
					nxt.seq = mdws_pkg::SEQ_IDLE;
				end else begin
					case (st.seq)
						mdws_pkg::SEQ_IDLE: begin
							nxt.step_start_ms = item.now_ms;
							if (!st.bl_sent_valid || (st.bl_sent != st.bl_target)) begin
								kind = mdws_pkg::WK_SINGLE;
								res.register_address = mdws_pkg::REG_BACKLIGHT;
								res.register_value = {3'd0, st.bl_target};
								nxt.seq = mdws_pkg::SEQ_BACKLIGHT;
							end else if (st.text_due) begin
								kind = mdws_pkg::WK_TEXT;
								res.register_address = mdws_pkg::REG_TEXT;
								nxt.seq = mdws_pkg::SEQ_TEXT;
							end
						end
						mdws_pkg::SEQ_BACKLIGHT: begin
							if (item.response_ok) begin
								res.clear_request = 1'b1;
								nxt.bl_sent = st.bl_target;
								nxt.bl_sent_valid = 1'b1;
								nxt.seq = mdws_pkg::SEQ_IDLE;
							end
						end
						mdws_pkg::SEQ_TEXT: begin
							if (item.response_ok) begin
								res.clear_request = 1'b1;
								kind = mdws_pkg::WK_LABEL;
								res.register_address = mdws_pkg::REG_LABEL;
								nxt.step_start_ms = item.now_ms;
								nxt.seq = mdws_pkg::SEQ_LABEL;
							end
						end
						mdws_pkg::SEQ_LABEL: begin
							if (item.response_ok) begin
								res.clear_request = 1'b1;
								kind = mdws_pkg::WK_SINGLE;
								res.register_address = mdws_pkg::REG_LCD_MODE;
								res.register_value = st.text_is_blank ?
									mdws_pkg::LCD_SHOW_ENERGY : mdws_pkg::LCD_SHOW_TEXT;
								nxt.step_start_ms = item.now_ms;
								nxt.seq = mdws_pkg::SEQ_LCD_MODE;
							end
						end
						mdws_pkg::SEQ_LCD_MODE: begin
							if (item.response_ok) begin
								res.clear_request = 1'b1;
								nxt.text_due = 1'b0;
								nxt.seq = mdws_pkg::SEQ_IDLE;
							end
						end
						default: nxt.seq = mdws_pkg::SEQ_IDLE;
					endcase
				end
			end
			mdws_pkg::OP_TEXT_CHANGED: begin
				nxt.text_is_blank = item.text_blank;
				nxt.text_due = 1'b1;
			end
			default: ;
		endcase
		res.write_kind = kind;
		res.target_address = (kind != mdws_pkg::WK_NONE) ? cfg.meter_bus_address : 8'd0;
		res.work_pending = (nxt.seq != mdws_pkg::SEQ_IDLE) || nxt.text_due ||
			!nxt.bl_sent_valid || (nxt.bl_sent != nxt.bl_target);
		res.backlight_wanted = nxt.bl_target;
	end

endmodule

// File: rtl/core/meter_display_write_sequencer.sv
// Channel   Handshake                    Beat
// item      item_valid / item_ready      mdws_pkg::item_t item
// result    result_valid / result_ready  mdws_pkg::result_t result
// config    wr_en                        wr_index, wr_data
//
// A beat is taken into the input register, processed from there and its result is held in
// the output register. One beat per cycle is sustained while the receiver takes results;
// the sequencer state updates as each result is formed.
// Reset clears the sequencer to idle and loads the register defaults.
// A stalled result holds the output register, and the input register then fills and stalls.
module meter_display_write_sequencer (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input mdws_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output mdws_pkg::result_t result,
	input logic wr_en,
	input logic [mdws_pkg::CFG_INDEX_W-1:0] wr_index,
	input logic [mdws_pkg::CFG_DATA_W-1:0] wr_data
);

	mdws_pkg::cfg_t cfg;
	mdws_pkg::item_t item_s1;
	logic valid_s1;
	mdws_pkg::result_t result_s2;
	logic valid_s2;
	mdws_pkg::state_t st_q;
	mdws_pkg::state_t st_nxt;
	mdws_pkg::result_t res_nxt;
	logic advance;
	logic fire;

	mdws_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.cfg(cfg)
	);

	mdws_step u_step (
		.item(item_s1),
		.st(st_q),
		.cfg(cfg),
		.nxt(st_nxt),
		.res(res_nxt)
	);

	assign advance = !valid_s2 || result_ready;
	assign fire = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (fire) begin
			result_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.seq <= mdws_pkg::SEQ_IDLE;
			st_q.step_start_ms <= '0;
			st_q.last_event_ms <= '0;
			st_q.bl_target <= 1'b0;
			st_q.bl_sent <= 1'b0;
			st_q.bl_sent_valid <= 1'b0;
			st_q.text_due <= 1'b0;
			st_q.text_is_blank <= 1'b1;
			st_q.was_charging <= 1'b0;
			st_q.was_pressed <= 1'b0;
			st_q.last_meter_kind <= '0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result = result_s2;

endmodule

// File: bench/display_write_checker.sv
`timescale 1ns / 100ps

module display_write_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input mdws_pkg::item_t item,
	input logic result_valid,
	input logic result_ready,
	input mdws_pkg::result_t result,
	input logic wr_en,
	input logic [mdws_pkg::CFG_INDEX_W-1:0] wr_index,
	input logic [mdws_pkg::CFG_DATA_W-1:0] wr_data,
	output int fail_count,
	output int outstanding,
	output int results_seen,
	output int drops_seen
);
	import mdws_pkg::*;

	cfg_t regs;
	state_t seq_st;
	result_t due_results[$];
	result_t want;

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] wanted);
		if (fail_count < 40) begin
			$display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, wanted);
		end
		fail_count++;
	endtask

	function automatic logic span_reached(logic [31:0] now, logic [31:0] start,
			logic [31:0] span);
		logic [31:0] gone;
		gone = now - start;
		return gone >= span;
	endfunction

	function automatic logic backlight_stale();
		return !seq_st.bl_sent_valid || (seq_st.bl_sent != seq_st.bl_target);
	endfunction

	function automatic result_t next_display_result(item_t it);
		result_t r;
		r = '0;
		case (it.op)
		OP_APP_TICK: begin
			if (it.meter_kind != seq_st.last_meter_kind) begin
				seq_st.last_meter_kind = it.meter_kind;
				if (it.meter_has_display) begin
					seq_st.bl_sent_valid = 1'b0;
					if (!seq_st.text_is_blank)
						seq_st.text_due = 1'b1;
				end
			end
			if (seq_st.was_charging && !it.ev_charging)
				seq_st.last_event_ms = it.now_ms;
			seq_st.was_charging = it.ev_charging;
			if (it.button_down && !seq_st.was_pressed)
				seq_st.last_event_ms = it.now_ms;
			seq_st.was_pressed = it.button_down;
			case (regs.light_mode)
			BL_MODE_OFF: seq_st.bl_target = 1'b0;
			BL_MODE_ON: seq_st.bl_target = 1'b1;
			default: seq_st.bl_target = it.ev_charging || (seq_st.last_event_ms != 32'd0 &&
					!span_reached(it.now_ms, seq_st.last_event_ms, regs.auto_off_ms));
			endcase
		end
		OP_BUS_TICK: begin
			if (seq_st.seq != SEQ_IDLE &&
					span_reached(it.now_ms, seq_st.step_start_ms,
						{16'd0, regs.bus_timeout_ms})) begin
				// The whole sequence is abandoned and the backlight counts as written.
				r.clear_request = 1'b1;
				seq_st.text_due = 1'b0;
				seq_st.bl_sent = seq_st.bl_target;
				seq_st.bl_sent_valid = 1'b1;
				seq_st.seq = SEQ_IDLE;
				drops_seen++;
			end else begin
				case (seq_st.seq)
				SEQ_IDLE: begin
					seq_st.step_start_ms = it.now_ms;
					if (backlight_stale()) begin
						r.write_kind = WK_SINGLE;
						r.register_address = REG_BACKLIGHT;
						r.register_value = {3'd0, seq_st.bl_target};
						seq_st.seq = SEQ_BACKLIGHT;
					end else if (seq_st.text_due) begin
						r.write_kind = WK_TEXT;
						r.register_address = REG_TEXT;
						seq_st.seq = SEQ_TEXT;
					end
				end
				SEQ_BACKLIGHT: if (it.response_ok) begin
					r.clear_request = 1'b1;
					seq_st.bl_sent = seq_st.bl_target;
					seq_st.bl_sent_valid = 1'b1;
					seq_st.seq = SEQ_IDLE;
				end
				SEQ_TEXT: if (it.response_ok) begin
					r.clear_request = 1'b1;
					r.write_kind = WK_LABEL;
					r.register_address = REG_LABEL;
					seq_st.step_start_ms = it.now_ms;
					seq_st.seq = SEQ_LABEL;
				end
				SEQ_LABEL: if (it.response_ok) begin
					r.clear_request = 1'b1;
					r.write_kind = WK_SINGLE;
					r.register_address = REG_LCD_MODE;
					r.register_value = seq_st.text_is_blank ? LCD_SHOW_ENERGY : LCD_SHOW_TEXT;
					seq_st.step_start_ms = it.now_ms;
					seq_st.seq = SEQ_LCD_MODE;
				end
				SEQ_LCD_MODE: if (it.response_ok) begin
					r.clear_request = 1'b1;
					seq_st.text_due = 1'b0;
					seq_st.seq = SEQ_IDLE;
				end
				default: seq_st.seq = SEQ_IDLE;
				endcase
			end
		end
		OP_TEXT_CHANGED: begin
			seq_st.text_is_blank = it.text_blank;
			seq_st.text_due = 1'b1;
		end
		default: ;
		endcase
		r.target_address = (r.write_kind != WK_NONE) ? regs.meter_bus_address : 8'd0;
		r.work_pending = (seq_st.seq != SEQ_IDLE) || seq_st.text_due || backlight_stale();
		r.backlight_wanted = seq_st.bl_target;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.light_mode = RST_LIGHT_MODE;
			regs.auto_off_ms = RST_AUTO_OFF_MS;
			regs.bus_timeout_ms = RST_BUS_TIMEOUT_MS;
			regs.meter_bus_address = RST_METER_BUS_ADDRESS;
			seq_st = '0;
			seq_st.seq = SEQ_IDLE;
			seq_st.text_is_blank = 1'b1;
			due_results.delete();
			fail_count = 0;
			outstanding = 0;
			results_seen = 0;
			drops_seen = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
				CFG_LIGHT_MODE: regs.light_mode = wr_data[1:0];
				CFG_AUTO_OFF_MS: regs.auto_off_ms = wr_data;
				CFG_BUS_TIMEOUT_MS: regs.bus_timeout_ms = wr_data[15:0];
				CFG_METER_BUS_ADDRESS: regs.meter_bus_address = wr_data[7:0];
				default: ;
				endcase
			end
			// Results are retired before new beats are predicted, so a result can never
			// be matched against a beat taken at the same edge.
			if (result_valid && result_ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					flag_mismatch("result with nothing due", result, '0);
				end else begin
					want = due_results.pop_front();
					if (result.clear_request !== want.clear_request)
						flag_mismatch("clear_request", result.clear_request, want.clear_request);
					if (result.write_kind !== want.write_kind)
						flag_mismatch("write_kind", result.write_kind, want.write_kind);
					if (result.target_address !== want.target_address)
						flag_mismatch("target_address", result.target_address,
								want.target_address);
					if (result.register_address !== want.register_address)
						flag_mismatch("register_address", result.register_address,
								want.register_address);
					if (result.register_value !== want.register_value)
						flag_mismatch("register_value", result.register_value,
								want.register_value);
					if (result.work_pending !== want.work_pending)
						flag_mismatch("work_pending", result.work_pending, want.work_pending);
					if (result.backlight_wanted !== want.backlight_wanted)
						flag_mismatch("backlight_wanted", result.backlight_wanted,
								want.backlight_wanted);
				end
			end
			if (item_valid && item_ready)
				due_results.push_back(next_display_result(item));
			outstanding = due_results.size();
		end
	end

endmodule

// File: bench/tb_meter_display_write_sequencer.sv
`timescale 1ns / 100ps

module tb_meter_display_write_sequencer;
	import mdws_pkg::*;

	localparam int CYCLE_LIMIT = 150000;
	localparam int BEATS_PER_PHASE = 75;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER_BEATS = 250;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] BL_MODE_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	int fail_count;
	int outstanding;
	int results_seen;
	int drops_seen;
	int cycles = 0;
	int beats_sent = 0;
	int n_app = 0;
	int n_bus = 0;
	int n_text = 0;
	int n_odd = 0;
	int n_cfg_writes = 0;
	logic hold_off = 1'b0;
	bit no_gaps = 1'b0;

	logic [31:0] clock_ms = '0;
	logic [31:0] jump_span = 32'd1000;
	logic [7:0] cur_kind = '0;
	logic charging = 1'b0;
	logic pressed = 1'b0;

	meter_display_write_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	display_write_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.results_seen(results_seen),
		.drops_seen(drops_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("meter_display_write_sequencer test failed");
			$finish;
		end
	end

	function automatic item_t mk(logic [1:0] op, logic [31:0] t, logic chg, logic btn,
			logic [7:0] kind, logic disp, logic ok, logic blank);
		item_t it;
		it.op = op;
		it.now_ms = t;
		it.ev_charging = chg;
		it.button_down = btn;
		it.meter_kind = kind;
		it.meter_has_display = disp;
		it.response_ok = ok;
		it.text_blank = blank;
		return it;
	endfunction

	function automatic item_t random_beat();
		item_t it;
		logic [63:0] noise;
		int pick;
		noise = {$urandom, $urandom};
		it = noise[$bits(item_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 80)
			clock_ms = clock_ms + $urandom_range(0, 20);
		else if (pick < 97)
			clock_ms = clock_ms + $urandom_range(0, jump_span);
		else
			clock_ms = $urandom;
		it.now_ms = clock_ms;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			it.op = OP_APP_TICK;
			if ($urandom_range(0, 99) < 12)
				cur_kind = 8'($urandom);
			if ($urandom_range(0, 9) == 0)
				charging = !charging;
			if ($urandom_range(0, 6) == 0)
				pressed = !pressed;
			it.meter_kind = cur_kind;
			it.ev_charging = charging;
			it.button_down = pressed;
			it.meter_has_display = ($urandom_range(0, 3) != 0);
		end else if (pick < 92) begin
			it.op = OP_BUS_TICK;
			it.response_ok = ($urandom_range(0, 4) != 0);
		end else begin
			it.op = OP_TEXT_CHANGED;
		end
		return it;
	endfunction

	task automatic send_beat(item_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		beats_sent++;
		case (it.op)
		OP_APP_TICK: n_app++;
		OP_BUS_TICK: n_bus++;
		OP_TEXT_CHANGED: n_text++;
		default: n_odd++;
		endcase
	endtask

	task automatic write_reg(cfg_index_t idx, logic [31:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		n_cfg_writes++;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(logic [1:0] mode, logic [31:0] auto_off, logic [15:0] tmo,
			logic [7:0] addr, logic [31:0] span, bit calm);
		settle();
		write_reg(CFG_LIGHT_MODE, {30'd0, mode});
		write_reg(CFG_AUTO_OFF_MS, auto_off);
		write_reg(CFG_BUS_TIMEOUT_MS, {16'd0, tmo});
		write_reg(CFG_METER_BUS_ADDRESS, {24'd0, addr});
		wr_en <= 1'b0;
		jump_span = span;
		no_gaps = calm;
		repeat (BEATS_PER_PHASE) send_beat(random_beat());
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_gaps ? 0 : $urandom_range(0, 10);
			if (stall != 0 || hold_off) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
				while (hold_off) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// The receiver stops taking results for a while so the input side backs up.
	initial begin
		wait (beats_sent >= HOLD_AFTER_BEATS);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		item_t odd;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_beat(mk(OP_APP_TICK, 32'd0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_APP_TICK, 32'd5, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_BUS_TICK, 32'd6, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_BUS_TICK, 32'd7, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
		send_beat(mk(OP_TEXT_CHANGED, 32'd8, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_BUS_TICK, 32'd10, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_TEXT_CHANGED, 32'd11, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
		send_beat(mk(OP_BUS_TICK, 32'd12, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
		send_beat(mk(OP_BUS_TICK, 32'd13, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
		send_beat(mk(OP_BUS_TICK, 32'd14, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
		send_beat(mk(OP_APP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b1));
		send_beat(mk(OP_APP_TICK, 32'd100, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0));
		send_beat(mk(OP_BUS_TICK, 32'd101, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_BUS_TICK, 32'd3101, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
		odd = '1;
		send_beat(odd);
		odd = '0;
		odd.op = OP_UNUSED;
		send_beat(odd);
		send_beat(mk(OP_TEXT_CHANGED, 32'd3200, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_BUS_TICK, 32'd3201, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
		send_beat(mk(OP_BUS_TICK, 32'h8000_0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_APP_TICK, 32'd303200, 1'b0, 1'b0, 8'h3C, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_APP_TICK, 32'd303210, 1'b0, 1'b0, 8'hC3, 1'b1, 1'b0, 1'b0));
		send_beat(mk(OP_BUS_TICK, 32'd303220, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0));

		clock_ms = 32'd303300;
		cur_kind = 8'hC3;
		jump_span = 32'd700000;
		repeat (BEATS_PER_PHASE) send_beat(random_beat());
		run_phase(BL_MODE_AUTO, 32'd200, 16'd60, 8'd247, 32'd400, 1'b0);
		run_phase(BL_MODE_OFF, 32'd1, 16'd1, 8'd0, 32'd50, 1'b1);
		run_phase(BL_MODE_ON, 32'hFFFF_FFFF, 16'hFFFF, 8'h5A, 32'd200000, 1'b0);
		run_phase(BL_MODE_SPARE, 32'd0, 16'd0, 8'd17, 32'd100, 1'b1);
		clock_ms = 32'hFFFF_FF00;
		run_phase(BL_MODE_AUTO, 32'd500, 16'd100, 8'd200, 32'd1000, 1'b0);
		settle();
		repeat (8) @(negedge clk);

		$display("Drove %0d beats: %0d application ticks, %0d bus ticks,",
				beats_sent, n_app, n_bus);
		$display("%0d text changes and %0d unused codes.", n_text, n_odd);
		$display("Checked %0d results over %0d register writes; %0d write sequences timed out.",
				results_seen, n_cfg_writes, drops_seen);
		if (fail_count == 0)
			$display("meter_display_write_sequencer test passed");
		else
			$display("meter_display_write_sequencer test failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/mdws_pkg.sv
rtl/core/mdws_cfg_regs.sv
rtl/core/mdws_step.sv
rtl/core/meter_display_write_sequencer.sv
bench/display_write_checker.sv
bench/tb_meter_display_write_sequencer.sv
